// ===== src/fdm_pkg.sv =====
// fdm_pkg: shared types and constants of the fat32 directory entry matcher
// no dependencies; imported by every module of the block
package fdm_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 64;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_NAME      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_EXT       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RESERVED_SECTORS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FAT_COUNT        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FAT_SECTORS      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CLUSTER_SECTORS  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SECTOR_BYTES     = 3'd6;

    // reset values of the volume geometry registers
    localparam logic [15:0] RESERVED_SECTORS_RST = 16'd32;
    localparam logic [7:0]  FAT_COUNT_RST        = 8'd2;
    localparam logic [7:0]  CLUSTER_SECTORS_RST  = 8'd1;
    localparam logic [12:0] SECTOR_BYTES_RST     = 13'd512;

    // special byte values
    localparam logic [7:0] BYTE_END     = 8'h00;
    localparam logic [7:0] BYTE_DELETED = 8'hE5;
    localparam logic [7:0] BYTE_KANJI   = 8'h05;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam int unsigned ATTR_HIDDEN_BIT = 1;

    localparam logic [31:0] EOC_LIMIT = 32'h0FFF_FFF8;
    localparam logic [33:0] CLUSTER_BASE = 34'd2;

    typedef struct packed {
        logic        first_in_dir;
        logic [63:0] entry_name;
        logic [23:0] entry_ext;
        logic [7:0]  entry_attr;
        logic [15:0] cluster_low;
        logic [15:0] cluster_high;
        logic [31:0] entry_size;
    } in_item_t;

    typedef struct packed {
        logic        listed;
        logic        end_reached;
        logic        matched;
        logic [31:0] start_cluster;
        logic        chain_end;
        logic [63:0] data_offset;
        logic [31:0] size_out;
    } out_item_t;

    // classified entry handed from the front to the back
    typedef struct packed {
        logic        listed;
        logic        end_reached;
        logic        matched;
        logic [31:0] start_cluster;
        logic        chain_end;
        logic [31:0] size_out;
    } cls_item_t;

    // volume geometry seen by the back
    typedef struct packed {
        logic [15:0] reserved_sectors;
        logic [39:0] fat_total;
        logic [7:0]  cluster_sectors;
        logic [12:0] sector_bytes;
    } geom_t;

endpackage

// ===== src/fdm_front.sv =====
// fdm_front: accepts directory entries, tracks the end marker and matches names
// depends on fdm_pkg
module fdm_front
    import fdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    input  logic [63:0] target_name,
    input  logic [23:0] target_ext,
    output logic        push_valid,
    input  logic        push_ready,
    output cls_item_t   push_item
);

    logic       end_seen_reg;
    logic       end_seen_next;
    logic       accept;
    logic [7:0] first_byte;
    logic       end_now;
    logic       name_ok;
    logic       ext_ok;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;
    assign first_byte = in_item.entry_name[7:0];
    assign end_now    = (in_item.first_in_dir ? 1'b0 : end_seen_reg) || (first_byte == BYTE_END);

    always_comb
    begin
        end_seen_next = end_seen_reg;
        if (accept)
        begin
            end_seen_next = end_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_seen_reg <= 1'b0;
        end
        else
        begin
            end_seen_reg <= end_seen_next;
        end
    end

    // name: trim trailing spaces, compare up to and including the first shared zero
    always_comb
    begin
        logic [7:0] nb;
        logic [7:0] tb;
        logic       tail;
        logic       stop;
        logic [7:0] trimmed [8];
        tail = 1'b1;
        for (int i = 7; i >= 0; i--)
        begin
            nb = in_item.entry_name[8*i +: 8];
            tail = tail && (nb == BYTE_SPACE);
            trimmed[i] = tail ? 8'h00 : nb;
        end
        name_ok = 1'b1;
        stop = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            tb = target_name[8*i +: 8];
            if (!stop && (trimmed[i] != tb))
            begin
                name_ok = 1'b0;
            end
            stop = stop || ((trimmed[i] == tb) && (tb == 8'h00));
        end
    end

    always_comb
    begin
        logic [7:0] xb;
        logic [7:0] tb;
        logic       tail;
        logic       stop;
        logic [7:0] trimmed [3];
        tail = 1'b1;
        for (int i = 2; i >= 0; i--)
        begin
            xb = in_item.entry_ext[8*i +: 8];
            tail = tail && (xb == BYTE_SPACE);
            trimmed[i] = tail ? 8'h00 : xb;
        end
        ext_ok = 1'b1;
        stop = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            tb = target_ext[8*i +: 8];
            if (!stop && (trimmed[i] != tb))
            begin
                ext_ok = 1'b0;
            end
            stop = stop || ((trimmed[i] == tb) && (tb == 8'h00));
        end
    end

    always_comb
    begin
        push_item.end_reached   = end_now;
        push_item.listed        = !end_now && (first_byte != BYTE_DELETED)
                                  && (first_byte != BYTE_KANJI)
                                  && !in_item.entry_attr[ATTR_HIDDEN_BIT];
        push_item.matched       = name_ok && ext_ok;
        push_item.start_cluster = {in_item.cluster_high, in_item.cluster_low};
        push_item.chain_end     = ({in_item.cluster_high, in_item.cluster_low} >= EOC_LIMIT);
        push_item.size_out      = in_item.entry_size;
    end

endmodule

// ===== src/fdm_queue.sv =====
// fdm_queue: small fifo of classified entries between front and back
// depends on fdm_pkg
module fdm_queue
    import fdm_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  cls_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output cls_item_t pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    cls_item_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/fdm_back.sv =====
// fdm_back: computes the cluster's sector, then its byte offset, and holds the result item
// depends on fdm_pkg
module fdm_back
    import fdm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  cls_item_t pop_item,
    input  geom_t     geom,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic               calc_valid_reg;
    logic               calc_valid_next;
    cls_item_t          calc_item_reg;
    logic signed [43:0] sector_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_item_reg;

    logic               out_free;
    logic               calc_load;
    logic               out_load;
    logic signed [33:0] clus_off;
    logic signed [42:0] clus_term;
    logic signed [43:0] sector_sum;
    logic signed [57:0] offset_prod;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = calc_valid_reg && out_free;
    assign calc_load = pop_valid && (!calc_valid_reg || out_free);
    assign pop_ready = !calc_valid_reg || out_free;

    // cluster term may go negative for clusters 0 and 1; sign extension gives the wrap
    assign clus_off   = $signed({2'b00, pop_item.start_cluster}) - $signed(CLUSTER_BASE);
    assign clus_term  = clus_off * $signed({1'b0, geom.cluster_sectors});
    assign sector_sum = $signed({28'd0, geom.reserved_sectors})
                        + $signed({4'd0, geom.fat_total})
                        + $signed({clus_term[42], clus_term});
    assign offset_prod = sector_reg * $signed({1'b0, geom.sector_bytes});

    always_comb
    begin
        calc_valid_next = calc_valid_reg;
        out_valid_next  = out_valid_reg;
        if (calc_load)
        begin
            calc_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            calc_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            calc_valid_reg <= calc_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_load)
        begin
            calc_item_reg <= pop_item;
            sector_reg    <= sector_sum;
        end
        if (out_load)
        begin
            out_item_reg.listed        <= calc_item_reg.listed;
            out_item_reg.end_reached   <= calc_item_reg.end_reached;
            out_item_reg.matched       <= calc_item_reg.matched;
            out_item_reg.start_cluster <= calc_item_reg.start_cluster;
            out_item_reg.chain_end     <= calc_item_reg.chain_end;
            out_item_reg.data_offset   <= {{6{offset_prod[57]}}, offset_prod};
            out_item_reg.size_out      <= calc_item_reg.size_out;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== src/fat32_dir_entry_matcher_top.sv =====
// channel | handshake           | payload
// --------+---------------------+------------------------------------------
// in      | in_valid / in_ready | in_item (in_item_t), one directory entry
// out     | out_valid/out_ready | out_item (out_item_t), one result item
// cfg     | cfg_we              | cfg_index, cfg_data (write only)
//
// an accepted item reaches out_valid through the registers in turn: it waits in the queue,
// its sector sum (cluster multiply and add) is registered as it leaves, then the byte offset
// multiply fills the output register; items can follow every cycle unless the output stalls
// reset clears the end flag, queue and pipeline valids and presets the config registers
// a stalled output holds the result while the queue keeps taking items until full
// fat_count * fat_sectors is registered in the cycle after a configuration write
//
// fat32_dir_entry_matcher_top: configuration registers and block wiring
// depends on fdm_pkg, fdm_front, fdm_queue, fdm_back
module fat32_dir_entry_matcher_top
    import fdm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [63:0] target_name_reg;
    logic [23:0] target_ext_reg;
    logic [15:0] reserved_sectors_reg;
    logic [7:0]  fat_count_reg;
    logic [31:0] fat_sectors_reg;
    logic [7:0]  cluster_sectors_reg;
    logic [12:0] sector_bytes_reg;
    logic [39:0] fat_total_reg;
    geom_t       geom;

    logic        push_valid;
    logic        push_ready;
    cls_item_t   push_item;
    logic        pop_valid;
    logic        pop_ready;
    cls_item_t   pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_name_reg      <= '0;
            target_ext_reg       <= '0;
            reserved_sectors_reg <= RESERVED_SECTORS_RST;
            fat_count_reg        <= FAT_COUNT_RST;
            fat_sectors_reg      <= '0;
            cluster_sectors_reg  <= CLUSTER_SECTORS_RST;
            sector_bytes_reg     <= SECTOR_BYTES_RST;
            fat_total_reg        <= '0;
        end
        else
        begin
            fat_total_reg <= fat_count_reg * fat_sectors_reg;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TARGET_NAME:      target_name_reg      <= cfg_data;
                    REG_TARGET_EXT:       target_ext_reg       <= cfg_data[23:0];
                    REG_RESERVED_SECTORS: reserved_sectors_reg <= cfg_data[15:0];
                    REG_FAT_COUNT:        fat_count_reg        <= cfg_data[7:0];
                    REG_FAT_SECTORS:      fat_sectors_reg      <= cfg_data[31:0];
                    REG_CLUSTER_SECTORS:  cluster_sectors_reg  <= cfg_data[7:0];
                    REG_SECTOR_BYTES:     sector_bytes_reg     <= cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        geom.reserved_sectors = reserved_sectors_reg;
        geom.fat_total        = fat_total_reg;
        geom.cluster_sectors  = cluster_sectors_reg;
        geom.sector_bytes     = sector_bytes_reg;
    end

    fdm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .target_name (target_name_reg),
        .target_ext  (target_ext_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    fdm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    fdm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .geom      (geom),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ===== bench/fat32_dir_entry_matcher_top_tb.sv =====
`timescale 1ns / 100ps
// fat32_dir_entry_matcher_top_tb: self-checking bench for the directory entry matcher
// drives directed and random entries, predicts each result in-bench; needs fdm_pkg and the rtl
module fat32_dir_entry_matcher_top_tb;
    import fdm_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [7:0] BYTE_NUL  = 8'h00;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 163;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef enum int {RX_FLOW, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    in_item_t               in_item = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_item;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // bench copy of the registers and the directory end flag
    logic [63:0] tgt_name = 64'h0;
    logic [23:0] tgt_ext = 24'h0;
    logic [15:0] geo_reserved = RESERVED_SECTORS_RST;
    logic [7:0]  geo_fats = FAT_COUNT_RST;
    logic [31:0] geo_fat_sectors = 32'h0;
    logic [7:0]  geo_cluster_sectors = CLUSTER_SECTORS_RST;
    logic [12:0] geo_sector_bytes = SECTOR_BYTES_RST;
    logic        dir_end_seen = 1'b0;

    in_item_t  pending_entries[$];
    out_item_t predicted_results[$];
    int        fail_count = 0;
    int        result_count = 0;
    int        idle_cycles = 0;
    logic      in_taken = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;
    rx_mode_t  rx_mode = RX_FLOW;
    int        rx_left = 0;

    always #5 clk = ~clk;

    fat32_dir_entry_matcher_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // trailing spaces of the low n bytes become zero
    function automatic logic [71:0] trim_spaces_tail(logic [71:0] v, int n);
        logic [71:0] r;
        logic        trailing;
        int          i;
        r = v;
        trailing = 1'b1;
        for (i = n - 1; i >= 0; i--)
        begin
            if (trailing && r[8*i +: 8] == BYTE_SPACE)
                r[8*i +: 8] = BYTE_NUL;
            else
                trailing = 1'b0;
        end
        return r;
    endfunction

    // byte compare that stops after the first shared zero
    function automatic logic part_match(logic [71:0] a, logic [71:0] b, int n);
        logic same;
        logic done;
        int   i;
        same = 1'b1;
        done = 1'b0;
        for (i = 0; i < n; i++)
        begin
            if (!done)
            begin
                if (a[8*i +: 8] != b[8*i +: 8])
                begin
                    same = 1'b0;
                    done = 1'b1;
                end
                else if (a[8*i +: 8] == BYTE_NUL)
                    done = 1'b1;
            end
        end
        return same;
    endfunction

    function automatic out_item_t classify_entry(in_item_t it);
        out_item_t   r;
        logic [7:0]  lead;
        logic [63:0] sector;
        lead = it.entry_name[7:0];
        if (it.first_in_dir)
            dir_end_seen = 1'b0;
        if (lead == BYTE_END)
            dir_end_seen = 1'b1;
        r.listed = !dir_end_seen && lead != BYTE_DELETED && lead != BYTE_KANJI
                   && !it.entry_attr[ATTR_HIDDEN_BIT];
        r.end_reached = dir_end_seen;
        r.matched = part_match(trim_spaces_tail({8'h00, it.entry_name}, 8),
                               {8'h00, tgt_name}, 9)
                    && part_match(trim_spaces_tail({48'h0, it.entry_ext}, 3),
                                  {48'h0, tgt_ext}, 4);
        r.start_cluster = {it.cluster_high, it.cluster_low};
        r.chain_end = r.start_cluster >= EOC_LIMIT;
        // clusters below two wrap, as does every product
        sector = {48'h0, geo_reserved} + {56'h0, geo_fats} * {32'h0, geo_fat_sectors}
                 + ({32'h0, r.start_cluster} - 64'd2) * {56'h0, geo_cluster_sectors};
        r.data_offset = sector * {51'h0, geo_sector_bytes};
        r.size_out = it.entry_size;
        return r;
    endfunction

    function automatic logic [63:0] pack_text(string s, int n, logic [7:0] pad);
        logic [63:0] v;
        int          i;
        v = 64'h0;
        for (i = 0; i < n; i++)
            v[8*i +: 8] = (i < s.len()) ? s[i] : pad;
        return v;
    endfunction

    function automatic logic [63:0] with_lead(logic [63:0] name, logic [7:0] lead);
        return {name[63:8], lead};
    endfunction

    function automatic logic [7:0] rand_char();
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(1, 255));
            1: return BYTE_SPACE;
            2, 3: return CHAR_ZERO + 8'($urandom_range(0, 9));
            default: return CHAR_A + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [63:0] rand_text(int n, int min_len, logic [7:0] pad);
        logic [63:0] v;
        int          len;
        int          i;
        v = 64'h0;
        len = $urandom_range(min_len, n);
        for (i = 0; i < n; i++)
            v[8*i +: 8] = (i < len) ? rand_char() : pad;
        return v;
    endfunction

    // target text up to its first zero, space padded after that
    function automatic logic [63:0] text_from_target(logic [63:0] tgt, int n);
        logic [63:0] v;
        logic        ended;
        int          i;
        v = 64'h0;
        ended = 1'b0;
        for (i = 0; i < n; i++)
        begin
            if (tgt[8*i +: 8] == BYTE_NUL)
                ended = 1'b1;
            v[8*i +: 8] = ended ? BYTE_SPACE : tgt[8*i +: 8];
        end
        return v;
    endfunction

    function automatic in_item_t dir_entry(logic first, logic [63:0] name, logic [63:0] ext,
                                           logic [7:0] attr, logic [31:0] clus,
                                           logic [31:0] size);
        in_item_t it;
        it.first_in_dir = first;
        it.entry_name = name;
        it.entry_ext = ext[23:0];
        it.entry_attr = attr;
        {it.cluster_high, it.cluster_low} = clus;
        it.entry_size = size;
        return it;
    endfunction

    function automatic in_item_t make_entry(logic first);
        in_item_t    it;
        logic [63:0] name;
        logic [63:0] ext;
        logic [31:0] clus;
        int          kind;
        int          pos;
        name = rand_text(8, 1, BYTE_SPACE);
        ext = rand_text(3, 0, BYTE_SPACE);
        it.first_in_dir = first;
        it.entry_attr = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) != 0)
            it.entry_attr[ATTR_HIDDEN_BIT] = 1'b0;
        case ($urandom_range(0, 9))
            0: clus = 32'($urandom_range(0, 2));
            1: clus = EOC_LIMIT - 32'd2 + 32'($urandom_range(0, 9));
            2: clus = $urandom;
            default: clus = 32'($urandom_range(2, 65535));
        endcase
        it.entry_size = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 100000));
        kind = $urandom_range(0, 99);
        if (kind >= 35 && kind < 65)
        begin
            name = text_from_target(tgt_name, 8);
            ext = text_from_target({40'h0, tgt_ext}, 3);
            // near miss: one byte of name or extension altered
            if (kind >= 55)
            begin
                pos = $urandom_range(0, 10);
                if (pos < 8)
                    name[8*pos +: 8] = rand_char();
                else
                    ext[8*(pos-8) +: 8] = rand_char();
            end
        end
        else if (kind >= 65 && kind < 73)
            name = with_lead(name, $urandom_range(0, 1) ? BYTE_DELETED : BYTE_KANJI);
        else if (kind >= 73 && kind < 79)
            name = with_lead(name, BYTE_END);
        else if (kind >= 79)
        begin
            name = {$urandom, $urandom};
            ext = {32'h0, $urandom};
            it.entry_attr = 8'($urandom_range(0, 255));
            it.first_in_dir = 1'($urandom_range(0, 1));
            clus = $urandom;
        end
        it.entry_name = name;
        it.entry_ext = ext[23:0];
        {it.cluster_high, it.cluster_low} = clus;
        return it;
    endfunction

    task automatic queue_directories(int count);
        int left;
        int dir_len;
        int j;
        left = count;
        while (left > 0)
        begin
            dir_len = $urandom_range(1, 24);
            if (dir_len > left)
                dir_len = left;
            // now and then a directory runs on without its opening flag
            for (j = 0; j < dir_len; j++)
                pending_entries.push_back(make_entry(j == 0 && $urandom_range(0, 9) != 0));
            left -= dir_len;
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value, logic dirty);
        logic [63:0] data;
        data = dirty ? {$urandom, $urandom} : 64'h0;
        case (idx)
            REG_TARGET_NAME:
            begin
                data = value;
                tgt_name = data;
            end
            REG_TARGET_EXT:
            begin
                data[23:0] = value[23:0];
                tgt_ext = data[23:0];
            end
            REG_RESERVED_SECTORS:
            begin
                data[15:0] = value[15:0];
                geo_reserved = data[15:0];
            end
            REG_FAT_COUNT:
            begin
                data[7:0] = value[7:0];
                geo_fats = data[7:0];
            end
            REG_FAT_SECTORS:
            begin
                data[31:0] = value[31:0];
                geo_fat_sectors = data[31:0];
            end
            REG_CLUSTER_SECTORS:
            begin
                data[7:0] = value[7:0];
                geo_cluster_sectors = data[7:0];
            end
            REG_SECTOR_BYTES:
            begin
                data[12:0] = value[12:0];
                geo_sector_bytes = data[12:0];
            end
            default: data = value;
        endcase
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic set_geometry(logic [63:0] name, logic [63:0] ext, logic [63:0] rsv,
                                logic [63:0] fats, logic [63:0] fsec, logic [63:0] csec,
                                logic [63:0] sbytes, logic dirty);
        write_reg(REG_TARGET_NAME, name, dirty);
        write_reg(REG_TARGET_EXT, ext, dirty);
        write_reg(REG_RESERVED_SECTORS, rsv, dirty);
        write_reg(REG_FAT_COUNT, fats, dirty);
        write_reg(REG_FAT_SECTORS, fsec, dirty);
        write_reg(REG_CLUSTER_SECTORS, csec, dirty);
        write_reg(REG_SECTOR_BYTES, sbytes, dirty);
        cfg_we <= 1'b0;
    endtask

    // hold until every item is in and every result is out, then let the pipe settle
    task automatic wait_drained();
        while (pending_entries.size() != 0 || in_valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
        if (fail_count < REPORT_LIMIT)
            $display("result %0d, %s: expected %h, got %h", result_count, field, want, got);
        fail_count++;
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (predicted_results.size() == 0)
            note_mismatch("no entry pending", 64'h0, {32'h0, got.start_cluster});
        else
        begin
            want = predicted_results.pop_front();
            if (got.listed !== want.listed)
                note_mismatch("listed", want.listed, got.listed);
            if (got.end_reached !== want.end_reached)
                note_mismatch("end_reached", want.end_reached, got.end_reached);
            if (got.matched !== want.matched)
                note_mismatch("matched", want.matched, got.matched);
            if (got.start_cluster !== want.start_cluster)
                note_mismatch("start_cluster", want.start_cluster, got.start_cluster);
            if (got.chain_end !== want.chain_end)
                note_mismatch("chain_end", want.chain_end, got.chain_end);
            if (got.data_offset !== want.data_offset)
                note_mismatch("data_offset", want.data_offset, got.data_offset);
            if (got.size_out !== want.size_out)
                note_mismatch("size_out", want.size_out, got.size_out);
        end
        result_count++;
    endtask

    // entry driver: bursts of items separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_entries.size() != 0)
            begin
                in_item <= pending_entries.pop_front();
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result sink stall pattern
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 30) : $urandom_range(8, 60);
        end
        rx_left--;
        case (rx_mode)
            RX_FLOW: out_ready <= 1'b1;
            RX_COIN: out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
            default: out_ready <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_result(out_item);
            if (in_valid && in_ready)
                predicted_results.push_back(classify_entry(in_item));
            in_taken = in_valid && in_ready;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("fat32_dir_entry_matcher_top_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        logic [63:0] sp_name;
        logic [63:0] sp_ext;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed entries under the reset geometry and an empty target
        sp_name = pack_text("", 8, BYTE_SPACE);
        sp_ext = pack_text("", 3, BYTE_SPACE);
        pending_entries.push_back(dir_entry(1'b1, pack_text("README", 8, BYTE_SPACE),
                                            pack_text("TXT", 3, BYTE_SPACE), 8'h20, 32'd2,
                                            32'd1234));
        pending_entries.push_back(dir_entry(1'b0, pack_text("HIDDEN", 8, BYTE_SPACE),
                                            pack_text("SYS", 3, BYTE_SPACE), 8'h02, 32'd3, 32'd0));
        pending_entries.push_back(dir_entry(1'b0, pack_text("VISIBLE", 8, BYTE_SPACE),
                                            pack_text("BIN", 3, BYTE_SPACE), 8'hFD, 32'd4, 32'd9));
        pending_entries.push_back(dir_entry(1'b0,
                                            with_lead(pack_text("XOLDFIL", 8, BYTE_SPACE),
                                                      BYTE_DELETED),
                                            pack_text("TMP", 3, BYTE_SPACE), 8'h00, 32'd5, 32'd7));
        pending_entries.push_back(dir_entry(1'b0,
                                            with_lead(pack_text("XKANJI", 8, BYTE_SPACE),
                                                      BYTE_KANJI),
                                            sp_ext, 8'h00, 32'd6, 32'd8));
        pending_entries.push_back(dir_entry(1'b0, pack_text("A B", 8, BYTE_SPACE),
                                            pack_text("C", 3, BYTE_SPACE), 8'h00, 32'd7, 32'd1));
        pending_entries.push_back(dir_entry(1'b0, pack_text("LONGNAME", 8, BYTE_SPACE),
                                            pack_text("DAT", 3, BYTE_SPACE), 8'h00, 32'd8, 32'd2));
        // all spaces trims to nothing and meets the empty target
        pending_entries.push_back(dir_entry(1'b0, sp_name, sp_ext, 8'h10, 32'd9, 32'd3));
        pending_entries.push_back(dir_entry(1'b0, pack_text("ZERO", 8, BYTE_SPACE), sp_ext,
                                            8'h00, 32'd0, 32'd4));
        pending_entries.push_back(dir_entry(1'b0, pack_text("ONE", 8, BYTE_SPACE), sp_ext,
                                            8'h00, 32'd1, 32'd5));
        pending_entries.push_back(dir_entry(1'b0, pack_text("NEAREOC", 8, BYTE_SPACE), sp_ext,
                                            8'h00, EOC_LIMIT - 32'd1, 32'd6));
        pending_entries.push_back(dir_entry(1'b0, pack_text("EOC", 8, BYTE_SPACE), sp_ext,
                                            8'h00, EOC_LIMIT, 32'd7));
        pending_entries.push_back(dir_entry(1'b0, pack_text("MAXCLUS", 8, BYTE_SPACE), sp_ext,
                                            8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // end marker, then entries that follow it in the same directory
        pending_entries.push_back(dir_entry(1'b0,
                                            with_lead(pack_text("XEND", 8, BYTE_SPACE), BYTE_END),
                                            sp_ext, 8'h00, 32'd10, 32'd0));
        pending_entries.push_back(dir_entry(1'b0, pack_text("AFTER", 8, BYTE_SPACE),
                                            pack_text("TXT", 3, BYTE_SPACE), 8'h00, 32'd11, 32'd1));
        pending_entries.push_back(dir_entry(1'b0, sp_name, sp_ext, 8'h00, 32'd12, 32'd2));
        pending_entries.push_back(dir_entry(1'b1, pack_text("NEWDIR", 8, BYTE_SPACE), sp_ext,
                                            8'h00, 32'd13, 32'd3));
        pending_entries.push_back(dir_entry(1'b1,
                                            with_lead(pack_text("XEMPTY", 8, BYTE_SPACE), BYTE_END),
                                            sp_ext, 8'h00, 32'd14, 32'd4));
        pending_entries.push_back(dir_entry(1'b0, 64'h0, 64'h0, 8'h00, 32'h0, 32'h0));
        pending_entries.push_back(dir_entry(1'b1, {64{1'b1}}, {64{1'b1}}, 8'hFF, 32'hFFFF_FFFF,
                                            32'hFFFF_FFFF));
        pending_entries.push_back(dir_entry(1'b1, pack_text("AB CD", 8, BYTE_SPACE),
                                            pack_text("A", 3, BYTE_SPACE), 8'h00, 32'd15, 32'd5));

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0: set_geometry(pack_text("README", 8, BYTE_NUL), pack_text("TXT", 3, BYTE_NUL),
                                32, 2, 1009, 8, 512, 1'b0);
                1: set_geometry(pack_text("ABCDEFGH", 8, BYTE_NUL),
                                pack_text("XYZ", 3, BYTE_NUL), 1, 1, 0, 1, 512, 1'b0);
                2: set_geometry(64'h0, 64'h0, 65535, 255, 32'hFFFF_FFFF, 128, 4096, 1'b1);
                3:
                begin
                    // ignored index, then a target with a hole and an all-zero geometry
                    write_reg(REG_UNUSED, {$urandom, $urandom}, 1'b0);
                    set_geometry(64'h0000_0043_0000_4241, 64'h41_0020, 0, 0, 0, 0, 0, 1'b1);
                end
                4: set_geometry(rand_text(8, 0, BYTE_NUL), rand_text(3, 0, BYTE_NUL),
                                $urandom_range(1, 65535), $urandom_range(1, 255), $urandom,
                                255, 8191, 1'b1);
                default: set_geometry(rand_text(8, 0, BYTE_NUL), rand_text(3, 0, BYTE_NUL),
                                      $urandom_range(1, 65535), $urandom_range(1, 255),
                                      $urandom, 64'd1 << $urandom_range(0, 7),
                                      64'd512 << $urandom_range(0, 3),
                                      1'($urandom_range(0, 1)));
            endcase
            queue_directories(PHASE_ITEMS);
        end

        wait_drained();
        fail_count += predicted_results.size();
        if (fail_count == 0)
            $display("fat32_dir_entry_matcher_top_tb OK");
        else
            $display("fat32_dir_entry_matcher_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
src/fdm_pkg.sv
src/fdm_front.sv
src/fdm_queue.sv
src/fdm_back.sv
src/fat32_dir_entry_matcher_top.sv
bench/fat32_dir_entry_matcher_top_tb.sv
